// ===== src/page_free_list_allocator_assert.svh =====
// Assertion macros used by the page free list allocator checker.
`ifndef PAGE_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define PAGE_FREE_LIST_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFLA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("page free list allocator: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PFLA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("page free list allocator: assertion failed");

`endif

// ===== src/pfla_pkg.sv =====
// Shared types, codes and defaults of the page free list allocator.
package pfla_pkg;

	// Fixed field widths.
	localparam int DATA_W    = 32;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 2;

	// Parameter defaults.
	localparam int PAGE_BYTES_DEF = 4096;
	localparam int MAX_PAGES_DEF  = 1024;

	// Register reset values.
	localparam logic [DATA_W-1:0] REGION_BASE_RST = 32'h0010_0000;
	localparam logic [DATA_W-1:0] REGION_TOP_RST  = 32'h0050_0000;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_BASE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOP  = 2'd1;

	// Operation codes.
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_RANGE = 2'd2,
		STATUS_ALIGN = 2'd3
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic sweep_clear;
		logic sweep_step;
		logic capture;
		logic commit;
	} pfla_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic sweep_last;
	} pfla_stat_t;

endpackage

// ===== src/pfla_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module pfla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/pfla_ctrl.sv =====
// Controller state machine: link sweep, transaction acceptance and result handoff.
module pfla_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	output logic                            out_valid,
	input  logic                            out_stall,
	input  logic                            wr_en,
	input  logic [pfla_pkg::CFG_IDX_W-1:0]  wr_index,
	output pfla_pkg::pfla_cmd_t             cmd,
	input  pfla_pkg::pfla_stat_t            stat
);
	import pfla_pkg::*;

	typedef enum logic [2:0] {
		ST_SWEEP = 3'b001,
		ST_IDLE  = 3'b010,
		ST_EXEC  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   cfg_wr;
	logic   out_free;

	// Only writes to a defined register rebuild the list.
	assign cfg_wr   = wr_en && ((wr_index == REG_BASE) || (wr_index == REG_TOP));
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || cfg_wr;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		if (cfg_wr) begin
			state_d         = ST_SWEEP;
			cmd.sweep_clear = 1'b1;
		end else begin
			case (state_q)
				ST_SWEEP: begin
					cmd.sweep_step = 1'b1;
					if (stat.sweep_last) begin
						state_d = ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						cmd.capture = 1'b1;
						state_d     = ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (out_free) begin
						cmd.commit = 1'b1;
						state_d    = ST_IDLE;
					end
				end
				default: begin
					state_d = ST_SWEEP;
				end
			endcase
		end
	end

	// State register; reset starts the link sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	// Output valid flag of the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== src/pfla_dp.sv =====
// Datapath: region registers, head pointer, link memory, checks and result register.
module pfla_dp #(
	parameter int PAGE_BYTES = pfla_pkg::PAGE_BYTES_DEF,
	parameter int MAX_PAGES  = pfla_pkg::MAX_PAGES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pfla_pkg::pfla_cmd_t             cmd,
	output pfla_pkg::pfla_stat_t            stat,
	input  logic                            operation,
	input  logic [pfla_pkg::DATA_W-1:0]     address,
	input  logic                            wr_en,
	input  logic [pfla_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [pfla_pkg::DATA_W-1:0]     wr_data,
	output logic [pfla_pkg::DATA_W-1:0]     page_address,
	output logic [pfla_pkg::STATUS_W-1:0]   status
);
	import pfla_pkg::*;

	// PAGE_BYTES must be a power of two (the block does not check it), so page arithmetic is shifts and masks.
	localparam int PB_LOG = $clog2(PAGE_BYTES);
	localparam int AW     = $clog2(MAX_PAGES);
	localparam int IW     = $clog2(MAX_PAGES + 1);
	localparam logic [IW-1:0]     NULL_IDX = IW'(MAX_PAGES);
	localparam logic [AW-1:0]     LAST_IDX = AW'(MAX_PAGES - 1);
	localparam logic [DATA_W:0]   MAX_WIDE = (DATA_W + 1)'(MAX_PAGES);
	localparam logic [DATA_W:0]   PB_M1    = (DATA_W + 1)'(PAGE_BYTES - 1);
	localparam logic [DATA_W-1:0] MAX_NARROW = DATA_W'(MAX_PAGES);

	logic [DATA_W-1:0] base_q;
	logic [DATA_W-1:0] top_q;
	logic [IW-1:0]     head_q;
	logic [AW-1:0]     sweep_q;
	logic              op_q;
	logic [DATA_W-1:0] addr_q;
	logic [DATA_W-1:0] page_q;
	status_t           status_q;

	logic              head_valid;
	logic [DATA_W:0]   span;
	logic [DATA_W:0]   page_cnt;
	logic [DATA_W:0]   page_cnt_m1;
	logic              region_ok;
	logic [IW-1:0]     head_init;
	logic [DATA_W-1:0] offset;
	logic [DATA_W-1:0] page_num;
	logic              free_range_bad;
	logic              free_misaligned;
	logic              free_ok;
	status_t           free_status;
	logic [DATA_W-1:0] alloc_addr;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [IW-1:0]     mem_wdata;
	logic [IW-1:0]     mem_rdata;

	assign head_valid      = (head_q != NULL_IDX);
	assign stat.sweep_last = (sweep_q == LAST_IDX);

	// Region registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= REGION_BASE_RST;
			top_q  <= REGION_TOP_RST;
		end else if (wr_en) begin
			if (wr_index == REG_BASE) begin
				base_q <= wr_data;
			end else if (wr_index == REG_TOP) begin
				top_q <= wr_data;
			end
		end
	end

	// Initial head: the topmost managed page, capped at the capacity.
	always_comb begin
		span        = {1'b0, top_q} - {1'b0, base_q};
		page_cnt    = (span + PB_M1) >> PB_LOG;
		page_cnt_m1 = page_cnt - (DATA_W + 1)'(1);
		region_ok   = (top_q > base_q) && (base_q[PB_LOG-1:0] == '0);
		if (!region_ok) begin
			head_init = NULL_IDX;
		end else if (page_cnt >= MAX_WIDE) begin
			head_init = IW'(MAX_PAGES - 1);
		end else begin
			head_init = page_cnt_m1[IW-1:0];
		end
	end

	// Sweep counter that rebuilds every link after reset or a write to the base or top register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.sweep_clear) begin
			sweep_q <= '0;
		end else if (cmd.sweep_step) begin
			if (stat.sweep_last) begin
				sweep_q <= '0;
			end else begin
				sweep_q <= sweep_q + AW'(1);
			end
		end
	end

	// Free checks on the captured address.
	always_comb begin
		offset          = addr_q - base_q;
		page_num        = offset >> PB_LOG;
		free_misaligned = (addr_q[PB_LOG-1:0] != '0) || (offset[PB_LOG-1:0] != '0);
		free_range_bad  = (addr_q < base_q) || (addr_q >= top_q);
		free_ok         = 1'b0;
		if (free_range_bad) begin
			free_status = STATUS_RANGE;
		end else if (free_misaligned) begin
			free_status = STATUS_ALIGN;
		end else if (page_num >= MAX_NARROW) begin
			free_status = STATUS_RANGE;
		end else begin
			free_status = STATUS_OK;
			free_ok     = 1'b1;
		end
	end

	// Address of the head page.
	assign alloc_addr = base_q + ({{(DATA_W - AW){1'b0}}, head_q[AW-1:0]} << PB_LOG);

	// Link memory write: sweep links or a pushed page.
	always_comb begin
		if (cmd.sweep_step) begin
			mem_we    = 1'b1;
			mem_waddr = sweep_q;
			mem_wdata = (sweep_q == '0) ? NULL_IDX : (IW'(sweep_q) - IW'(1));
		end else begin
			mem_we    = cmd.commit && (op_q == OP_FREE) && free_ok;
			mem_waddr = page_num[AW-1:0];
			mem_wdata = head_q;
		end
	end

	pfla_ram #(
		.WIDTH (IW),
		.DEPTH (MAX_PAGES)
	) u_link_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (cmd.capture && head_valid),
		.raddr (head_q[AW-1:0]),
		.rdata (mem_rdata)
	);

	// Capture of the incoming transaction.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= operation;
			addr_q <= address;
		end
	end

	// Head pointer: loaded at the end of the sweep, moved by pops and pushes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= NULL_IDX;
		end else if (cmd.sweep_step && stat.sweep_last) begin
			head_q <= head_init;
		end else if (cmd.commit) begin
			if (op_q == OP_ALLOC) begin
				if (head_valid) begin
					head_q <= mem_rdata;
				end
			end else if (free_ok) begin
				head_q <= page_num[IW-1:0];
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (op_q == OP_ALLOC) begin
				page_q   <= head_valid ? alloc_addr : '0;
				status_q <= head_valid ? STATUS_OK : STATUS_EMPTY;
			end else begin
				page_q   <= '0;
				status_q <= free_status;
			end
		end
	end

	assign page_address = page_q;
	assign status       = status_q;

endmodule

// ===== src/page_free_list_allocator.sv =====
// Top level of the LIFO free list page allocator.
//
//  Channel   Handshake               Payload
//  input     in_valid / in_stall     operation, address
//  result    out_valid / out_stall   page_address, status
//  config    wr_en                   wr_index, wr_data
//
// A transaction is accepted in ST_IDLE, which reads the head's link from the link
// memory; in ST_EXEC the head is updated and the result register is loaded.
// After reset and after every write to the base or top register the link memory is
// swept, one entry a cycle, over all MAX_PAGES entries; in_stall stays high during the sweep.
// A held result stalls the next transaction in ST_EXEC until it is taken.
module page_free_list_allocator #(
	parameter int PAGE_BYTES = pfla_pkg::PAGE_BYTES_DEF,
	parameter int MAX_PAGES  = pfla_pkg::MAX_PAGES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            operation,
	input  logic [pfla_pkg::DATA_W-1:0]     address,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [pfla_pkg::DATA_W-1:0]     page_address,
	output logic [pfla_pkg::STATUS_W-1:0]   status,
	input  logic                            wr_en,
	input  logic [pfla_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [pfla_pkg::DATA_W-1:0]     wr_data
);
	import pfla_pkg::*;

	pfla_cmd_t  cmd;
	pfla_stat_t stat;

	// Sequencing and handshake.
	pfla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.cmd       (cmd),
		.stat      (stat)
	);

	// Free list storage and arithmetic.
	pfla_dp #(
		.PAGE_BYTES (PAGE_BYTES),
		.MAX_PAGES  (MAX_PAGES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.operation    (operation),
		.address      (address),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.page_address (page_address),
		.status       (status)
	);

endmodule

// ===== src/pfla_checker.sv =====
// Port-level checker of the page free list allocator and its bind.
`include "page_free_list_allocator_assert.svh"

module pfla_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic [pfla_pkg::DATA_W-1:0]     page_address,
	input  logic [pfla_pkg::STATUS_W-1:0]   status,
	input  logic                            wr_en,
	input  logic [pfla_pkg::CFG_IDX_W-1:0]  wr_index
);
	import pfla_pkg::*;

	// A stalled result holds.
	`PFLA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable({page_address, status}))

	// Only one transaction is in flight: the cycle after an acceptance is stalled.
	`PFLA_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall)

	// A write to the base or top register starts the link sweep, which stalls the input.
	`PFLA_ASSERT_NEXT(a_cfg_sweep, wr_en && ((wr_index == REG_BASE) || (wr_index == REG_TOP)), in_stall)

	// A failed transaction never returns an address.
	`PFLA_ASSERT_NOW(a_fail_zero, out_valid && (status != STATUS_OK), page_address == '0)

	// A new result appears only when the input was stalled just before out_valid rose.
	`PFLA_ASSERT_NOW(a_result_after_exec, $rose(out_valid), $past(in_stall))

endmodule

bind page_free_list_allocator pfla_checker u_pfla_checker (.*);

// ===== test/tb_page_free_list_allocator.sv =====
// Self-checking testbench of the LIFO free list page allocator.
module tb_page_free_list_allocator;
	timeunit 1ns;
	timeprecision 1ps;

	import pfla_pkg::*;

	localparam int unsigned PAGE           = PAGE_BYTES_DEF;
	localparam int unsigned NPAGES         = MAX_PAGES_DEF;
	localparam int unsigned CLK_PERIOD     = 12;
	localparam int unsigned RESET_CYCLES   = 4;
	localparam int unsigned SETTLE_CYCLES  = 4;
	localparam int unsigned TAIL_CYCLES    = 16;
	localparam int unsigned WATCHDOG_LIMIT = 4 * (NPAGES + 64);
	localparam int unsigned PHASES         = 10;
	localparam int unsigned PHASE_ITEMS    = 165;

	// Register indexes past the end of the register list.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	typedef enum logic [1:0] {
		KIND_REQUEST,
		KIND_REG_WRITE,
		KIND_DRAIN
	} step_kind_t;

	// One entry of the stimulus queue.
	typedef struct {
		step_kind_t             kind;
		logic                   op;
		logic [DATA_W-1:0]      addr;
		logic [CFG_IDX_W-1:0]   reg_idx;
		logic [DATA_W-1:0]      reg_data;
		int unsigned            gap;
	} stim_step_t;

	// Expected outcome of one request.
	typedef struct {
		logic [DATA_W-1:0] page;
		status_t           st;
	} alloc_result_t;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic                   operation = OP_ALLOC;
	logic [DATA_W-1:0]      address = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [DATA_W-1:0]      page_address;
	logic [STATUS_W-1:0]    status;
	logic                   wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]   wr_index = REG_BASE;
	logic [DATA_W-1:0]      wr_data = '0;

	stim_step_t     request_q[$];
	alloc_result_t  expected_results[$];
	int unsigned    fail_cnt = 0;
	int unsigned    gap_cnt = 0;
	int unsigned    settle_cnt = 0;
	int unsigned    stall_cnt = 0;
	int unsigned    idle_cycles = 0;
	bit             tx_quiet = 1'b0;
	bit             rx_quiet = 1'b0;

	// Predicted allocator state.
	logic [DATA_W-1:0]  fl_base = REGION_BASE_RST;
	logic [DATA_W-1:0]  fl_top = REGION_TOP_RST;
	int unsigned        fl_head;
	int unsigned        fl_link[NPAGES];

	// Region as seen by the stimulus generator.
	logic [DATA_W-1:0]  gen_base = REGION_BASE_RST;
	logic [DATA_W-1:0]  gen_top = REGION_TOP_RST;

	page_free_list_allocator #(
		.PAGE_BYTES(PAGE_BYTES_DEF),
		.MAX_PAGES(MAX_PAGES_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.address(address),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.page_address(page_address),
		.status(status),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	always begin
		clk = 1'b1;
		#(CLK_PERIOD / 2);
		clk = 1'b0;
		#(CLK_PERIOD / 2);
	end

	// Every managed page free, topmost at the head, each linking to the one below.
	function automatic void rebuild_free_list();
		logic [63:0]  span;
		logic [63:0]  count;
		int unsigned  i;
		count = '0;
		if (fl_top > fl_base && fl_base % PAGE == 0) begin
			span = {32'd0, fl_top} - {32'd0, fl_base};
			count = (span + PAGE - 1) / PAGE;
			if (count > NPAGES)
				count = NPAGES;
		end
		for (i = 0; i < NPAGES; i++)
			fl_link[i] = (i == 0) ? NPAGES : i - 1;
		fl_head = (count == 0) ? NPAGES : int'(count) - 1;
	endfunction

	function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
		case (idx)
			REG_BASE: begin
				fl_base = data;
				rebuild_free_list();
			end
			REG_TOP: begin
				fl_top = data;
				rebuild_free_list();
			end
			default: ;
		endcase
	endfunction

	// Pops the head on an allocate, pushes a checked page on a free.
	function automatic alloc_result_t apply_request(logic op, logic [DATA_W-1:0] addr);
		alloc_result_t      res;
		logic [DATA_W-1:0]  offs;
		int unsigned        idx;
		res.page = '0;
		res.st = STATUS_OK;
		offs = addr - fl_base;
		if (op == OP_ALLOC) begin
			if (fl_head >= NPAGES) begin
				res.st = STATUS_EMPTY;
			end else begin
				res.page = fl_base + DATA_W'(fl_head * PAGE);
				fl_head = fl_link[fl_head];
			end
		end else if (addr < fl_base || addr >= fl_top) begin
			res.st = STATUS_RANGE;
		end else if (addr % PAGE != 0 || offs % PAGE != 0) begin
			res.st = STATUS_ALIGN;
		end else begin
			idx = offs / PAGE;
			if (idx >= NPAGES) begin
				res.st = STATUS_RANGE;
			end else begin
				fl_link[idx] = fl_head;
				fl_head = idx;
			end
		end
		return res;
	endfunction

	// Stimulus queue builders.
	task automatic push_request(logic op, logic [DATA_W-1:0] addr);
		stim_step_t step;
		step.kind = KIND_REQUEST;
		step.op = op;
		step.addr = addr;
		step.reg_idx = REG_BASE;
		step.reg_data = '0;
		step.gap = tx_quiet ? 0 : $urandom_range(4, 0);
		if ($urandom_range(39, 0) == 0)
			tx_quiet = !tx_quiet;
		request_q.push_back(step);
	endtask

	task automatic push_write(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
		stim_step_t step;
		step.kind = KIND_REG_WRITE;
		step.op = OP_ALLOC;
		step.addr = '0;
		step.reg_idx = idx;
		step.reg_data = data;
		step.gap = 0;
		if (idx == REG_BASE)
			gen_base = data;
		else if (idx == REG_TOP)
			gen_top = data;
		request_q.push_back(step);
	endtask

	task automatic push_drain();
		stim_step_t step;
		step.kind = KIND_DRAIN;
		step.op = OP_ALLOC;
		step.addr = '0;
		step.reg_idx = REG_BASE;
		step.reg_data = '0;
		step.gap = 0;
		request_q.push_back(step);
	endtask

	// A page slot of the current region, past the managed capacity now and then.
	function automatic logic [DATA_W-1:0] pick_page();
		logic [63:0]  span;
		logic [63:0]  pages;
		if (gen_top <= gen_base)
			return $urandom;
		span = {32'd0, gen_top} - {32'd0, gen_base};
		pages = (span + PAGE - 1) / PAGE;
		if (pages > NPAGES + 64)
			pages = NPAGES + 64;
		return gen_base + DATA_W'($urandom_range(int'(pages) - 1, 0) * PAGE);
	endfunction

	// Mostly allocates and frees of real pages, with bad frees mixed in.
	task automatic random_requests(int unsigned n_items, bit spare_writes);
		int unsigned        i;
		int unsigned        r;
		logic [DATA_W-1:0]  a;
		for (i = 0; i < n_items; i++) begin
			if (spare_writes && i == n_items / 2) begin
				push_write(REG_SPARE_2, $urandom);
				push_write(REG_SPARE_3, $urandom);
			end else if (i == n_items / 3 && $urandom_range(1, 0) == 1) begin
				push_drain();
			end
			r = $urandom_range(99, 0);
			if (r < 45) begin
				push_request(OP_ALLOC, $urandom);
			end else if (r < 80) begin
				push_request(OP_FREE, pick_page());
			end else if (r < 88) begin
				if (gen_base != 0 && $urandom_range(1, 0) == 1)
					a = $urandom_range(gen_base - 1, 0);
				else if ($urandom_range(3, 0) == 0)
					a = gen_top;
				else
					a = $urandom_range(32'hFFFF_FFFF, gen_top);
				push_request(OP_FREE, a);
			end else if (r < 95) begin
				push_request(OP_FREE, pick_page() + $urandom_range(PAGE - 1, 1));
			end else begin
				push_request(OP_FREE, $urandom);
			end
		end
	endtask

	// Driver: presents queued requests and performs register writes once all results are in.
	always @(posedge clk or negedge arst_n) begin : request_driver
		logic           drive_valid;
		logic           drive_wr;
		stim_step_t     step;
		alloc_result_t  res;
		if (!arst_n) begin
			in_valid <= 1'b0;
			wr_en <= 1'b0;
			gap_cnt = 0;
			settle_cnt = 0;
			rebuild_free_list();
		end else begin
			drive_valid = in_valid;
			drive_wr = 1'b0;
			if (wr_en)
				apply_reg_write(wr_index, wr_data);
			// A request transaction completes on this edge.
			if (in_valid && !in_stall) begin
				res = apply_request(operation, address);
				expected_results.push_back(res);
				drive_valid = 1'b0;
			end
			if (!drive_valid && !wr_en && request_q.size() != 0) begin
				step = request_q[0];
				case (step.kind)
					KIND_REQUEST: begin
						if (gap_cnt < step.gap) begin
							gap_cnt++;
						end else begin
							operation <= step.op;
							address <= step.addr;
							drive_valid = 1'b1;
							gap_cnt = 0;
							void'(request_q.pop_front());
						end
					end
					KIND_DRAIN: begin
						if (expected_results.size() == 0)
							void'(request_q.pop_front());
					end
					KIND_REG_WRITE: begin
						// Write only when idle and the previous list sweep is over.
						if (expected_results.size() != 0) begin
							settle_cnt = 0;
						end else begin
							settle_cnt++;
							if (settle_cnt >= SETTLE_CYCLES &&
									(!in_stall || settle_cnt >= SETTLE_CYCLES + NPAGES + 16)) begin
								wr_index <= step.reg_idx;
								wr_data <= step.reg_data;
								drive_wr = 1'b1;
								settle_cnt = 0;
								void'(request_q.pop_front());
							end
						end
					end
					default: ;
				endcase
			end
			in_valid <= drive_valid;
			wr_en <= drive_wr;
		end
	end

	// Monitor: checks each result transaction and stalls the result channel at random.
	always @(posedge clk or negedge arst_n) begin : result_monitor
		alloc_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_cnt = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result: page_address %h, status %0d", page_address, status);
					fail_cnt++;
				end else begin
					want = expected_results.pop_front();
					if (page_address !== want.page) begin
						$error("page_address mismatch: expected %h, got %h", want.page, page_address);
						fail_cnt++;
					end
					if (status !== want.st) begin
						$error("status mismatch: expected %0d, got %0d", want.st, status);
						fail_cnt++;
					end
				end
				stall_cnt = rx_quiet ? 0 : $urandom_range(4, 0);
				if ($urandom_range(49, 0) == 0)
					rx_quiet = !rx_quiet;
			end
			if (stall_cnt != 0) begin
				stall_cnt--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog on cycles without any transaction or register write.
	always @(posedge clk) begin : stall_watchdog
		if (!arst_n) begin
			idle_cycles = 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall) || wr_en) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", idle_cycles);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [DATA_W-1:0]  b;
		logic [DATA_W-1:0]  t;
		int unsigned        p;
		int unsigned        n;

		// Default region: pops, pushes, and each kind of rejected free.
		push_request(OP_ALLOC, 32'hFFFF_FFFF);
		push_request(OP_ALLOC, 32'h0000_0000);
		push_request(OP_FREE, 32'h004F_F000);
		push_request(OP_FREE, 32'h0000_0000);
		push_request(OP_FREE, 32'hFFFF_FFFF);
		push_request(OP_FREE, 32'h0050_0000);
		push_request(OP_FREE, 32'h004F_FFFF);
		push_request(OP_FREE, 32'h0010_0800);
		push_request(OP_FREE, 32'h0010_0000);
		push_request(OP_ALLOC, 32'h0010_0000);
		push_request(OP_ALLOC, 32'h1234_5678);
		push_request(OP_ALLOC, 32'h0000_0000);

		// Region wider than the page capacity: a free past the last managed page.
		push_write(REG_BASE, 32'h0000_0000);
		push_write(REG_TOP, 32'h0100_0000);
		push_request(OP_FREE, 32'h0040_0000);
		push_request(OP_FREE, 32'h003F_F000);
		push_request(OP_ALLOC, 32'h0000_0000);

		// Single partial page at the top of the address space.
		push_write(REG_BASE, 32'hFFFF_F000);
		push_write(REG_TOP, 32'hFFFF_FFFF);
		push_request(OP_ALLOC, 32'h0000_0000);
		push_request(OP_ALLOC, 32'h0000_0000);
		push_request(OP_FREE, 32'hFFFF_F000);
		push_request(OP_FREE, 32'hFFFF_FFFF);
		push_request(OP_FREE, 32'hFFFF_F001);

		// Misaligned base: the list starts empty.
		push_write(REG_BASE, 32'h0000_1001);
		push_write(REG_TOP, 32'h0001_0000);
		push_request(OP_ALLOC, 32'h0000_0000);
		push_request(OP_FREE, 32'h0000_2000);

		// Top at or below base: nothing is managed.
		push_write(REG_BASE, 32'hFFFF_FFFF);
		push_request(OP_ALLOC, 32'h0000_0000);
		push_write(REG_BASE, 32'h0000_8000);
		push_write(REG_TOP, 32'h0000_4000);
		push_request(OP_ALLOC, 32'h0000_0000);

		// Random phases, each over a fresh region.
		for (p = 0; p < PHASES; p++) begin
			n = $urandom_range(16, 1);
			case (p)
				0: begin
					b = REGION_BASE_RST;
					t = REGION_TOP_RST;
				end
				1: begin
					b = $urandom_range(255, 0) * PAGE;
					t = b + (NPAGES + 40) * PAGE;
				end
				PHASES - 1: begin
					b = DATA_W'(0) - DATA_W'(n * PAGE);
					t = 32'hFFFF_FFFF;
				end
				default: begin
					b = $urandom_range(32'h000F_FFEF, 0) * PAGE;
					t = b + n * PAGE;
					if ($urandom_range(1, 0) == 1)
						t = t - $urandom_range(PAGE - 1, 0);
				end
			endcase
			if ($urandom_range(1, 0) == 1) begin
				push_write(REG_BASE, b);
				push_write(REG_TOP, t);
			end else begin
				push_write(REG_TOP, t);
				push_write(REG_BASE, b);
			end
			random_requests(PHASE_ITEMS, p == 4);
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every request to be accepted and every result to be checked.
		while (request_q.size() != 0 || expected_results.size() != 0 || in_valid || wr_en)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d expected results never arrived", expected_results.size());
			fail_cnt++;
		end
		if (fail_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
